// File: rtl/hci_uart_h4_deframer_macros.svh
// Assertion helpers used by the deframer parser (h4d_parser).
// Each helper expects signals named aclk and aresetn in the enclosing module.
`ifndef HCI_UART_H4_DEFRAMER_MACROS_SVH
`define HCI_UART_H4_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define H4D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define H4D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/h4d_pkg.sv
`default_nettype none

package h4d_pkg;

    // H4 packet kinds as carried on the result channel
    localparam logic [1:0] KIND_ACL   = 2'd0;
    localparam logic [1:0] KIND_SYNC  = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    // sticky error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_TYPE = 2'd1;
    localparam logic [1:0] ERR_LONG = 2'd2;
    localparam logic [1:0] ERR_LINE = 2'd3;

    // H4 packet type bytes
    localparam logic [7:0] TYPE_FIRST = 8'h02;
    localparam logic [7:0] TYPE_LAST  = 8'h04;

    // vendor bytes dropped during download
    localparam logic [7:0] VENDOR_BYTE_A = 8'h34;
    localparam logic [7:0] VENDOR_BYTE_B = 8'h31;

    localparam logic [15:0] MAX_ACL_RESET = 16'd1020;

    localparam logic CFG_IDX_MAX_ACL  = 1'b0;
    localparam logic CFG_IDX_DOWNLOAD = 1'b1;

    // one received byte
    typedef struct packed {
        logic       line_error;
        logic [7:0] rx_byte;
    } h4d_rx_t;

    // one result beat
    typedef struct packed {
        logic [1:0] error_kind;
        logic       frame_last;
        logic       in_header;
        logic [1:0] packet_kind;
        logic [7:0] frame_byte;
    } h4d_beat_t;

    // handshake between the input register and the parser
    typedef struct packed {
        logic valid;
        logic step;
    } h4d_ctl_t;

endpackage

`default_nettype wire

// File: rtl/h4d_in_reg.sv
`default_nettype none

module h4d_in_reg
    import h4d_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire h4d_rx_t s_item,
    input  wire logic    step,
    output h4d_ctl_t     ctl,
    output h4d_rx_t      item
);

    logic    valid_reg;
    logic    valid_next;
    h4d_rx_t item_reg;

    // take a new byte when empty or when the held one moves on this cycle
    assign s_ready    = !valid_reg || step;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.step  = step;
    assign item      = item_reg;

endmodule

`default_nettype wire

// File: rtl/h4d_parser.sv
`default_nettype none
`include "hci_uart_h4_deframer_macros.svh"

module h4d_parser
    import h4d_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire h4d_ctl_t    ctl,
    input  wire h4d_rx_t     item,
    input  wire logic [15:0] max_acl_payload,
    input  wire logic        download_mode,
    output logic             res_valid,
    output h4d_beat_t        res
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [2:0]  hcount_reg, hcount_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [15:0] remain_reg, remain_next;

    logic [2:0]  hlen;
    logic [2:0]  hcount_inc;
    logic [15:0] frame_len;
    logic [15:0] remain_dec;
    logic [7:0]  type_off;

    always_comb begin
        case (kind_reg)
            KIND_ACL:  hlen = 3'd4;
            KIND_SYNC: hlen = 3'd3;
            default:   hlen = 3'd2;
        endcase
    end

    assign hcount_inc = hcount_reg + 3'd1;
    assign frame_len  = (kind_reg == KIND_ACL) ? {item.rx_byte, len_low_reg}
                                               : {8'd0, item.rx_byte};
    assign remain_dec = (remain_reg != 16'd0) ? remain_reg - 16'd1 : 16'd0;
    assign type_off   = item.rx_byte - TYPE_FIRST;

    always_comb begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        hcount_next  = hcount_reg;
        len_low_next = len_low_reg;
        remain_next  = remain_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (phase_reg == PH_ERROR) begin
            // repeat the held code for every byte until reset
            res_valid      = 1'b1;
            res.error_kind = kind_reg;
        end else if (item.line_error) begin
            res_valid      = 1'b1;
            res.error_kind = ERR_LINE;
            phase_next     = PH_ERROR;
            kind_next      = ERR_LINE;
            hcount_next    = 3'd0;
            remain_next    = 16'd0;
        end else begin
            case (phase_reg)
                PH_TYPE: begin
                    if (item.rx_byte inside {[TYPE_FIRST:TYPE_LAST]}) begin
                        kind_next   = type_off[1:0];
                        hcount_next = 3'd0;
                        phase_next  = PH_HEADER;
                    end else if (download_mode && (item.rx_byte == VENDOR_BYTE_A ||
                                                   item.rx_byte == VENDOR_BYTE_B)) begin
                        // drop vendor byte
                    end else begin
                        res_valid      = 1'b1;
                        res.error_kind = ERR_TYPE;
                        phase_next     = PH_ERROR;
                        kind_next      = ERR_TYPE;
                        hcount_next    = 3'd0;
                        remain_next    = 16'd0;
                    end
                end
                PH_HEADER: begin
                    if (hcount_inc < hlen) begin
                        if (kind_reg == KIND_ACL && hcount_reg == 3'd2) begin
                            len_low_next = item.rx_byte;
                        end
                        hcount_next     = hcount_inc;
                        res_valid       = 1'b1;
                        res.frame_byte  = item.rx_byte;
                        res.packet_kind = kind_reg;
                        res.in_header   = 1'b1;
                    end else begin
                        hcount_next = 3'd0;
                        res_valid   = 1'b1;
                        if (kind_reg == KIND_ACL && frame_len > max_acl_payload) begin
                            res.error_kind = ERR_LONG;
                            phase_next     = PH_ERROR;
                            kind_next      = ERR_LONG;
                            remain_next    = 16'd0;
                        end else begin
                            res.frame_byte  = item.rx_byte;
                            res.packet_kind = kind_reg;
                            res.in_header   = 1'b1;
                            if (frame_len == 16'd0) begin
                                // empty payload: frame ends at the header
                                res.frame_last = 1'b1;
                                phase_next     = PH_TYPE;
                            end else begin
                                remain_next = frame_len;
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    remain_next     = remain_dec;
                    res_valid       = 1'b1;
                    res.frame_byte  = item.rx_byte;
                    res.packet_kind = kind_reg;
                    res.frame_last  = (remain_dec == 16'd0);
                    if (remain_dec == 16'd0) begin
                        phase_next = PH_TYPE;
                    end
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TYPE;
            kind_reg    <= 2'd0;
            hcount_reg  <= 3'd0;
            len_low_reg <= 8'd0;
            remain_reg  <= 16'd0;
        end else if (ctl.valid && ctl.step) begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            hcount_reg  <= hcount_next;
            len_low_reg <= len_low_next;
            remain_reg  <= remain_next;
        end
    end

    `H4D_ASSERT_NEXT(a_error_sticky, phase_reg == PH_ERROR, phase_reg == PH_ERROR, "error phase left before reset")
    `H4D_ASSERT_NOW(a_error_repeats, phase_reg == PH_ERROR && ctl.valid, res_valid && res.error_kind == kind_reg && kind_reg != ERR_NONE, "error phase gave no error result")
    `H4D_ASSERT_NOW(a_payload_count, phase_reg == PH_PAYLOAD, remain_reg != 16'd0, "payload phase with nothing left")
    `H4D_ASSERT_NOW(a_header_count, phase_reg == PH_HEADER, hcount_reg < hlen, "header count past header length")

endmodule

`default_nettype wire

// File: rtl/h4d_out_reg.sv
`default_nettype none

module h4d_out_reg
    import h4d_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire h4d_beat_t beat,
    output logic           can_load,
    output logic           m_valid,
    input  wire logic      m_ready,
    output h4d_beat_t      m_beat
);

    logic      valid_reg;
    logic      valid_next;
    h4d_beat_t beat_reg;

    // free when empty or when the held beat is taken this cycle
    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= beat;
        end
    end

    assign m_valid = valid_reg;
    assign m_beat  = beat_reg;

endmodule

`default_nettype wire

// File: rtl/hci_uart_h4_deframer.sv
// HCI UART (H4) receive deframer.
// s_ channel: one UART byte per transfer, tdata = received byte, tuser = line
// error flag. m_ channel: one transfer per header or payload byte, tdata = the
// byte, tlast = final byte of the frame, tuser = kind, header flag, error code.
// The packet type byte and, in download mode, vendor bytes 0x34/0x31 produce
// no transfer. After an unknown type, an oversized ACL length or a line error
// every further byte produces an error transfer until reset.
// cfg channel: index 0 = largest ACL payload (16 bits), 1 = download mode.
// Write it only while no byte is in flight; cfg_ready is always high.
// Path: each byte is held in the input register, the parser turns it into a
// result, and the result register presents that on m_; one byte per cycle is
// sustained while m_tready stays high, with the header/payload state updated
// between those registers.
// Stalls: when m_tready is low the result register holds, one more byte waits
// in the input register, then s_tready drops.
// Reset (aresetn low, synchronous): both registers empty, parser waits for a
// type byte, ACL limit 1020, download mode off.
`default_nettype none

module hci_uart_h4_deframer
    import h4d_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // received byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] line_error
    // frame bytes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] frame_byte
    output logic             m_tlast,   // frame_last
    output logic [4:0]       m_tuser,   // [1:0] packet_kind, [2] in_header, [4:3] error_kind
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] max_acl_reg;
    logic        download_reg;

    h4d_rx_t   s_item;
    h4d_rx_t   item;
    h4d_ctl_t  ctl;
    logic      step;
    logic      res_valid;
    h4d_beat_t res;
    logic      out_free;
    h4d_beat_t m_beat;

    // registers accept a write every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_acl_reg  <= MAX_ACL_RESET;
            download_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index[0] == CFG_IDX_MAX_ACL) begin
                max_acl_reg <= cfg_data;
            end else begin
                download_reg <= cfg_data[0];
            end
        end
    end

    assign s_item.rx_byte    = s_tdata;
    assign s_item.line_error = s_tuser[0];

    // advance the held byte only when the result register can take its result
    assign step = ctl.valid && out_free;

    h4d_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .step    (step),
        .ctl     (ctl),
        .item    (item)
    );

    h4d_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .item            (item),
        .max_acl_payload (max_acl_reg),
        .download_mode   (download_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    h4d_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .beat     (res),
        .can_load (out_free),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_beat   (m_beat)
    );

    assign m_tdata = m_beat.frame_byte;
    assign m_tlast = m_beat.frame_last;
    assign m_tuser = {m_beat.error_kind, m_beat.in_header, m_beat.packet_kind};

endmodule

`default_nettype wire
